[rtl/hkd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and keycode-to-ASCII functions for the HID keyboard
// report decoder. No dependencies; every other file of the block imports it.
package hkd_pkg;

	// Report geometry and widths
	localparam int KEY_SLOTS    = 6;
	localparam int AGE_BITS_DEF = 10;
	localparam int CFG_BITS     = 10;
	localparam int QUEUE_DEPTH  = 2;
	localparam int PADDR_W      = 4;

	// Register map (index = paddr[3:2])
	localparam logic [1:0] REG_PENDING_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_REPEAT_DELAY    = 2'd1;
	localparam logic [1:0] REG_REPEAT_PERIOD   = 2'd2;

	localparam logic [CFG_BITS-1:0] RST_PENDING_TIMEOUT = 10'd25;
	localparam logic [CFG_BITS-1:0] RST_REPEAT_DELAY    = 10'd350;
	localparam logic [CFG_BITS-1:0] RST_REPEAT_PERIOD   = 10'd55;

	// Keycodes and modifier mask
	localparam logic [7:0] SHIFT_MASK   = 8'h22;
	localparam logic [7:0] KC_LETTER_LO = 8'h04;
	localparam logic [7:0] KC_LETTER_HI = 8'h1d;
	localparam logic [7:0] KC_ENTER     = 8'h28;
	localparam logic [7:0] KC_ESCAPE    = 8'h29;
	localparam logic [7:0] KC_BACKSPACE = 8'h2a;
	localparam logic [7:0] KC_RIGHT     = 8'h4f;
	localparam logic [7:0] KC_LEFT      = 8'h50;

	typedef enum logic [2:0] {
		EV_CHAR      = 3'd0,
		EV_ENTER     = 3'd1,
		EV_BACKSPACE = 3'd2,
		EV_LEFT      = 3'd3,
		EV_RIGHT     = 3'd4,
		EV_ESCAPE    = 3'd5
	} event_kind_t;

	// What the front end decided about one slot of a report
	typedef enum logic [2:0] {
		SK_NONE  = 3'd0,
		SK_ESC   = 3'd1,
		SK_ENTER = 3'd2,
		SK_BKSP  = 3'd3,
		SK_LEFT  = 3'd4,
		SK_RIGHT = 3'd5,
		SK_PRINT = 3'd6
	} slot_kind_t;

	// One classified item on its way from front to back
	typedef struct packed {
		logic                             tick;
		logic                             shift;
		logic [KEY_SLOTS-1:0][7:0]        keys;
		slot_kind_t [KEY_SLOTS-1:0]       kind;
		logic [KEY_SLOTS-1:0][6:0]        chr;
	} item_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] pending_timeout;
		logic [CFG_BITS-1:0] repeat_delay;
		logic [CFG_BITS-1:0] repeat_period;
	} cfg_t;

	function automatic logic has_shift(input logic [7:0] mods);
		return (mods & SHIFT_MASK) != 8'h00;
	endfunction

	// Keycode to ASCII under the given shift state; 0 for unmapped codes
	function automatic logic [6:0] ascii_of(input logic [7:0] kc, input logic sh);
		logic [6:0] c;
		c = 7'h00;
		if (kc >= KC_LETTER_LO && kc <= KC_LETTER_HI) begin
			c = (sh ? 7'h41 : 7'h61) + 7'(kc - KC_LETTER_LO);
		end else begin
			case (kc)
				8'h1e: c = sh ? 7'h21 : 7'h31;
				8'h1f: c = sh ? 7'h40 : 7'h32;
				8'h20: c = sh ? 7'h23 : 7'h33;
				8'h21: c = sh ? 7'h24 : 7'h34;
				8'h22: c = sh ? 7'h25 : 7'h35;
				8'h23: c = sh ? 7'h5e : 7'h36;
				8'h24: c = sh ? 7'h26 : 7'h37;
				8'h25: c = sh ? 7'h2a : 7'h38;
				8'h26: c = sh ? 7'h28 : 7'h39;
				8'h27: c = sh ? 7'h29 : 7'h30;
				8'h2c: c = 7'h20;
				8'h2d: c = sh ? 7'h5f : 7'h2d;
				8'h2e: c = sh ? 7'h2b : 7'h3d;
				8'h2f: c = sh ? 7'h7b : 7'h5b;
				8'h30: c = sh ? 7'h7d : 7'h5d;
				8'h31: c = sh ? 7'h7c : 7'h5c;
				8'h33: c = sh ? 7'h3a : 7'h3b;
				8'h34: c = sh ? 7'h22 : 7'h27;
				8'h35: c = sh ? 7'h7e : 7'h60;
				8'h36: c = sh ? 7'h3c : 7'h2c;
				8'h37: c = sh ? 7'h3e : 7'h2e;
				8'h38: c = sh ? 7'h3f : 7'h2f;
				default: c = 7'h00;
			endcase
		end
		return c;
	endfunction

endpackage

[rtl/hkd_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input items, finds newly pressed keys against the last
// report and classifies each slot. Depends on hkd_pkg.
module hkd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [7:0]                        mods,
	input  logic [hkd_pkg::KEY_SLOTS-1:0][7:0] keys,
	output logic                              push_valid,
	input  logic                              push_ready,
	output hkd_pkg::item_t                    push_item
);
	import hkd_pkg::*;

	logic [7:0] prev_q [KEY_SLOTS];
	logic [KEY_SLOTS-1:0] is_new;
	logic report_shift;

	assign in_ready     = push_ready;
	assign push_valid   = in_valid;
	assign report_shift = has_shift(mods);

	// Mark slots whose keycode is nonzero and absent from the last report
	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			is_new[i] = (keys[i] != 8'h00);
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (prev_q[j] == keys[i]) is_new[i] = 1'b0;
			end
		end
	end

	// Classify each slot and look up its character
	always_comb begin
		push_item.tick  = cmd;
		push_item.shift = report_shift;
		push_item.keys  = keys;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			push_item.chr[i] = ascii_of(keys[i], report_shift);
			if (!is_new[i]) begin
				push_item.kind[i] = SK_NONE;
			end else begin
				case (keys[i])
					KC_ESCAPE:    push_item.kind[i] = SK_ESC;
					KC_ENTER:     push_item.kind[i] = SK_ENTER;
					KC_BACKSPACE: push_item.kind[i] = SK_BKSP;
					KC_LEFT:      push_item.kind[i] = SK_LEFT;
					KC_RIGHT:     push_item.kind[i] = SK_RIGHT;
					default: begin
						push_item.kind[i] = (push_item.chr[i] != 7'h00) ? SK_PRINT : SK_NONE;
					end
				endcase
			end
		end
	end

	// Remember the keys of every report transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_SLOTS; i++) prev_q[i] <= 8'h00;
		end else if (in_valid && push_ready && !cmd) begin
			for (int i = 0; i < KEY_SLOTS; i++) prev_q[i] <= keys[i];
		end
	end

endmodule

[rtl/hkd_queue.sv]
`timescale 1ns / 1ps
// Short FIFO of classified items between front and back end.
// Depends on hkd_pkg for the item type.
module hkd_queue #(
	parameter int DEPTH = hkd_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  hkd_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop,
	output hkd_pkg::item_t pop_item
);
	import hkd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            entry_q [DEPTH];
	logic [PTR_W-1:0] rd_q, wr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = entry_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Store pushed items
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_q] <= push_item;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[rtl/hkd_back.sv]
`timescale 1ns / 1ps
// Back end: sequencer that walks one classified report slot by slot, keeps the
// held-key and repeat state, and drives the output register. Depends on hkd_pkg.
module hkd_back #(
	parameter int AGE_BITS = hkd_pkg::AGE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  hkd_pkg::cfg_t  cfg,
	input  logic           q_valid,
	input  hkd_pkg::item_t q_item,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     out_kind,
	output logic [6:0]     out_char,
	output logic           out_last
);
	import hkd_pkg::*;

	localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int CMP_W  = (AGE_BITS > CFG_BITS) ? AGE_BITS : CFG_BITS;
	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_HELD   = 5'b00010,
		ST_SLOT   = 5'b00100,
		ST_REPEAT = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	function automatic logic [AGE_BITS-1:0] sat_inc(input logic [AGE_BITS-1:0] v);
		return (v == AGE_MAX) ? v : v + 1'b1;
	endfunction

	state_t              state_q, n_state;
	logic [SLOT_W-1:0]   slot_q, n_slot;
	logic                held_active_q, n_held_active;
	logic [7:0]          held_kc_q, n_held_kc;
	logic                held_sh_q, n_held_sh;
	logic [AGE_BITS-1:0] held_age_q, n_held_age;
	logic                rep_active_q, n_rep_active;
	logic [7:0]          rep_kc_q, n_rep_kc;
	logic [AGE_BITS-1:0] rep_held_q, n_rep_held;
	logic [AGE_BITS-1:0] rep_since_q, n_rep_since;

	logic                pend_v_q;
	event_kind_t         pend_kind_q;
	logic [6:0]          pend_chr_q;
	logic                out_v_q;
	event_kind_t         out_kind_q;
	logic [6:0]          out_chr_q;
	logic                out_last_q;

	logic                gen, flush, pop_c, adv, stall, load;
	event_kind_t         gen_kind;
	logic [6:0]          gen_chr;
	logic                held_in, rep_in;
	logic [7:0]          lk_kc;
	logic                lk_sh;
	logic [6:0]          lk_chr;
	logic [7:0]          cur_kc;
	slot_kind_t          cur_kind;
	logic [6:0]          cur_chr;
	logic [CMP_W-1:0]    held_age_x, rep_held_x, rep_since_x;
	logic [CMP_W-1:0]    timeout_x, delay_x, period_x;

	assign cur_kc   = q_item.keys[slot_q];
	assign cur_kind = q_item.kind[slot_q];
	assign cur_chr  = q_item.chr[slot_q];

	assign held_age_x  = CMP_W'(held_age_q);
	assign rep_held_x  = CMP_W'(rep_held_q);
	assign rep_since_x = CMP_W'(rep_since_q);
	assign timeout_x   = CMP_W'(cfg.pending_timeout);
	assign delay_x     = CMP_W'(cfg.repeat_delay);
	assign period_x    = CMP_W'(cfg.repeat_period);

	// Presence of the held and repeating keys in the current report
	always_comb begin
		held_in = 1'b0;
		rep_in  = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (q_item.keys[i] == held_kc_q) held_in = 1'b1;
			if (q_item.keys[i] == rep_kc_q)  rep_in  = 1'b1;
		end
	end

	// Shared character lookup for commits and repeats
	always_comb begin
		lk_kc = held_kc_q;
		lk_sh = held_sh_q;
		case (state_q)
			ST_HELD:   lk_sh = (held_in && q_item.shift) || held_sh_q;
			ST_SLOT:   lk_sh = (cur_kind == SK_ENTER) ? (q_item.shift || held_sh_q) : held_sh_q;
			ST_REPEAT: begin
				lk_kc = rep_kc_q;
				lk_sh = q_item.shift;
			end
			default:   lk_sh = held_sh_q;
		endcase
		lk_chr = ascii_of(lk_kc, lk_sh);
	end

	// Sequencer: next state and the event raised this cycle
	always_comb begin
		n_state       = state_q;
		n_slot        = slot_q;
		n_held_active = held_active_q;
		n_held_kc     = held_kc_q;
		n_held_sh     = held_sh_q;
		n_held_age    = held_age_q;
		n_rep_active  = rep_active_q;
		n_rep_kc      = rep_kc_q;
		n_rep_held    = rep_held_q;
		n_rep_since   = rep_since_q;
		gen      = 1'b0;
		gen_kind = EV_CHAR;
		gen_chr  = 7'h00;
		flush    = 1'b0;
		pop_c    = 1'b0;
		adv      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_item.tick) begin
						n_held_age  = sat_inc(held_age_q);
						n_rep_held  = sat_inc(rep_held_q);
						n_rep_since = sat_inc(rep_since_q);
						pop_c       = 1'b1;
					end else begin
						n_state = ST_HELD;
					end
				end
			end
			ST_HELD: begin
				// Commit a held key on Shift, release or timeout
				if (held_active_q && (!held_in || q_item.shift || held_age_x >= timeout_x)) begin
					gen           = (lk_chr != 7'h00);
					gen_chr       = lk_chr;
					n_held_active = 1'b0;
				end
				n_state = ST_SLOT;
				n_slot  = '0;
			end
			ST_SLOT: begin
				case (cur_kind)
					SK_ESC: begin
						n_held_active = 1'b0;
						gen           = 1'b1;
						gen_kind      = EV_ESCAPE;
						n_state       = ST_REPEAT;
					end
					SK_ENTER, SK_LEFT, SK_RIGHT: begin
						if (held_active_q) begin
							// commit first, revisit this slot next cycle
							gen           = (lk_chr != 7'h00);
							gen_chr       = lk_chr;
							n_held_active = 1'b0;
						end else begin
							gen      = 1'b1;
							gen_kind = (cur_kind == SK_ENTER) ? EV_ENTER :
							           (cur_kind == SK_LEFT)  ? EV_LEFT : EV_RIGHT;
							adv      = 1'b1;
						end
					end
					SK_BKSP: begin
						if (held_active_q) begin
							n_held_active = 1'b0;
						end else begin
							gen      = 1'b1;
							gen_kind = EV_BACKSPACE;
						end
						adv = 1'b1;
					end
					SK_PRINT: begin
						n_rep_active = 1'b1;
						n_rep_kc     = cur_kc;
						n_rep_held   = '0;
						n_rep_since  = '0;
						if (q_item.shift) begin
							gen     = 1'b1;
							gen_chr = cur_chr;
							adv     = 1'b1;
						end else if (held_active_q) begin
							gen           = (lk_chr != 7'h00);
							gen_chr       = lk_chr;
							n_held_active = 1'b0;
						end else begin
							n_held_active = 1'b1;
							n_held_kc     = cur_kc;
							n_held_sh     = 1'b0;
							n_held_age    = '0;
							adv           = 1'b1;
						end
					end
					default: adv = 1'b1;
				endcase
				if (adv) begin
					if (slot_q == SLOT_W'(KEY_SLOTS - 1)) n_state = ST_REPEAT;
					else n_slot = slot_q + 1'b1;
				end
			end
			ST_REPEAT: begin
				if (rep_active_q && !(held_active_q && held_kc_q == rep_kc_q)) begin
					if (!rep_in) begin
						n_rep_active = 1'b0;
						n_rep_kc     = 8'h00;
					end else if (rep_held_x >= delay_x && rep_since_x >= period_x) begin
						gen         = (lk_chr != 7'h00);
						gen_chr     = lk_chr;
						n_rep_since = '0;
					end
				end
				n_state = ST_DONE;
			end
			ST_DONE: begin
				flush   = 1'b1;
				pop_c   = 1'b1;
				n_state = ST_IDLE;
			end
			default: n_state = ST_IDLE;
		endcase
	end

	// Hold the sequencer while the staged event cannot move to the output
	assign stall = pend_v_q && (gen || flush) && out_v_q && !out_ready;
	assign load  = !stall && pend_v_q && (gen || flush);
	assign q_pop = pop_c && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			slot_q        <= '0;
			held_active_q <= 1'b0;
			held_kc_q     <= 8'h00;
			held_sh_q     <= 1'b0;
			held_age_q    <= '0;
			rep_active_q  <= 1'b0;
			rep_kc_q      <= 8'h00;
			rep_held_q    <= '0;
			rep_since_q   <= '0;
			pend_v_q      <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			if (!stall) begin
				state_q       <= n_state;
				slot_q        <= n_slot;
				held_active_q <= n_held_active;
				held_kc_q     <= n_held_kc;
				held_sh_q     <= n_held_sh;
				held_age_q    <= n_held_age;
				rep_active_q  <= n_rep_active;
				rep_kc_q      <= n_rep_kc;
				rep_held_q    <= n_rep_held;
				rep_since_q   <= n_rep_since;
				if (gen)        pend_v_q <= 1'b1;
				else if (flush) pend_v_q <= 1'b0;
			end
			if (load)           out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	// Stage the newest event; move the previous one out, marked last on flush
	always_ff @(posedge clk) begin
		if (!stall && gen) begin
			pend_kind_q <= gen_kind;
			pend_chr_q  <= gen_chr;
		end
		if (load) begin
			out_kind_q <= pend_kind_q;
			out_chr_q  <= pend_chr_q;
			out_last_q <= flush;
		end
	end

	assign out_valid = out_v_q;
	assign out_kind  = out_kind_q;
	assign out_char  = out_chr_q;
	assign out_last  = out_last_q;

endmodule

[rtl/hid_keyboard_report_decoder_top.sv]
`timescale 1ns / 1ps
// Top level of the HID boot-keyboard report decoder: APB register file plus
// front end, item queue and back-end sequencer. Depends on hkd_pkg.
//
//  channel   handshake               payload
//  -------   ---------------------   -------------------------------------------
//  input     in_valid / in_ready     cmd, modifier_bits, key_slot_0..key_slot_5
//  output    out_valid / out_ready   event_kind, char_code, last_of_run
//  config    psel/penable/pwrite     paddr[3:0], pwdata, prdata, pready
//
// A tick is handled in the idle state. A report passes the idle, held, slot, repeat
// and done states, revisiting a slot per held key committed before an Enter, Left,
// Right or printable key. Unless an output stall holds it, the sequencer visits one
// slot and raises one event per cycle; an Escape ends the slot walk early.
// The queue holds QUEUE_DEPTH classified items, so inputs keep flowing while a
// report is walked; an output stall holds the sequencer only when an event is due.
// No clearing pass: the block takes items from the first cycle after reset.
module hid_keyboard_report_decoder_top #(
	parameter int AGE_BITS    = hkd_pkg::AGE_BITS_DEF,
	parameter int QUEUE_DEPTH = hkd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  modifier_bits,
	input  logic [7:0]  key_slot_0,
	input  logic [7:0]  key_slot_1,
	input  logic [7:0]  key_slot_2,
	input  logic [7:0]  key_slot_3,
	input  logic [7:0]  key_slot_4,
	input  logic [7:0]  key_slot_5,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic [6:0]  char_code,
	output logic        last_of_run,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hkd_pkg::*;

	cfg_t                      cfg_q;
	logic [KEY_SLOTS-1:0][7:0] keys;
	logic                      push_valid, push_ready, pop_valid, pop;
	item_t                     push_item, pop_item;
	logic                      wr_en;
	logic [1:0]                reg_idx;

	assign keys = {key_slot_5, key_slot_4, key_slot_3, key_slot_2, key_slot_1, key_slot_0};

	// Register writes on the access phase; unknown indexes are dropped
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pending_timeout <= RST_PENDING_TIMEOUT;
			cfg_q.repeat_delay    <= RST_REPEAT_DELAY;
			cfg_q.repeat_period   <= RST_REPEAT_PERIOD;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PENDING_TIMEOUT: cfg_q.pending_timeout <= pwdata[CFG_BITS-1:0];
				REG_REPEAT_DELAY:    cfg_q.repeat_delay    <= pwdata[CFG_BITS-1:0];
				REG_REPEAT_PERIOD:   cfg_q.repeat_period   <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_PENDING_TIMEOUT: prdata = 32'(cfg_q.pending_timeout);
			REG_REPEAT_DELAY:    prdata = 32'(cfg_q.repeat_delay);
			REG_REPEAT_PERIOD:   prdata = 32'(cfg_q.repeat_period);
			default:             prdata = 32'h0;
		endcase
	end

	hkd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.mods       (modifier_bits),
		.keys       (keys),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	hkd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	hkd_back #(.AGE_BITS(AGE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (pop_valid),
		.q_item    (pop_item),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_kind  (event_kind),
		.out_char  (char_code),
		.out_last  (last_of_run)
	);

endmodule

[rtl/hkd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the HID keyboard report decoder, bound to its top level.
// Depends on hkd_pkg for event codes.
module hkd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] event_kind,
	input logic [6:0] char_code,
	input logic       last_of_run
);
	import hkd_pkg::*;

	// Stalled output transfer holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
		$stable(char_code) && $stable(last_of_run))
		else $error("output payload changed while stalled");

	// Character events carry a code, all others carry zero
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((event_kind == EV_CHAR) == (char_code != 7'h00)))
		else $error("char_code does not match event_kind");

	// Only defined event codes leave the block
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_kind <= EV_ESCAPE)
		else $error("undefined event_kind");

	// Out of reset the block is empty and ready for input
	a_reset_state: assert property (@(posedge clk)
		$rose(arst_n) |-> in_ready && !out_valid)
		else $error("block not empty after reset");

endmodule

bind hid_keyboard_report_decoder_top hkd_checker u_hkd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.event_kind  (event_kind),
	.char_code   (char_code),
	.last_of_run (last_of_run)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for hid_keyboard_report_decoder_top: drives reports and
// ticks, decodes them in a local key-event predictor and checks every event transfer.
// Depends on hkd_pkg and the decoder RTL.
module tb_top;
	import hkd_pkg::*;

	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         DRAIN_CYCLES = 64;
	localparam logic [9:0] AGE_MAX      = 10'h3ff;

	// Keycode ranges of the ASCII map
	localparam logic [7:0] KC_DIGIT_LO      = 8'h1e;
	localparam logic [7:0] KC_DIGIT_HI      = 8'h27;
	localparam logic [7:0] KC_PUNCT_LO      = 8'h2c;
	localparam logic [7:0] KC_PUNCT_HI      = 8'h38;
	localparam logic [7:0] KC_NON_US_HASH   = 8'h32;
	localparam logic [7:0] KC_GRAVE         = 8'h35;
	localparam logic [1:0] REG_UNUSED       = 2'd3;

	typedef struct packed {
		event_kind_t kind;
		logic [6:0]  chr;
		logic        last;
	} key_event_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        cmd;
	logic [7:0]  modifier_bits;
	logic [7:0]  key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_kind;
	logic [6:0]  char_code;
	logic        last_of_run;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	hid_keyboard_report_decoder_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .modifier_bits(modifier_bits),
		.key_slot_0(key_slot_0), .key_slot_1(key_slot_1), .key_slot_2(key_slot_2),
		.key_slot_3(key_slot_3), .key_slot_4(key_slot_4), .key_slot_5(key_slot_5),
		.out_valid(out_valid), .out_ready(out_ready), .event_kind(event_kind),
		.char_code(char_code), .last_of_run(last_of_run),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// Predictor copy of registers and decoder state
	logic [9:0]      cfg_timeout, cfg_delay, cfg_period;
	logic [5:0][7:0] last_keys;
	logic            held_on;
	logic [7:0]      held_kc, held_mods;
	logic [9:0]      held_age;
	logic            rpt_on;
	logic [7:0]      rpt_kc;
	logic [9:0]      rpt_held, rpt_since;

	key_event_t expected_events[$];
	key_event_t report_events[$];

	string digit_lo = "1234567890";
	string digit_hi = "!@#$%^&*()";
	// Placeholders at the unmapped and grave positions are never read
	string punct_lo = " -=[]\\_;'_,./";
	string punct_hi = " _+{}|_:\"~<>?";

	int  fail_count = 0;
	int  cycle_count = 0;
	int  n_reports = 0, n_ticks = 0, n_events = 0, n_settings = 0;
	bit  no_idle = 1'b0;
	int  stall_left = 0;

	function automatic logic shifted(input logic [7:0] mods);
		return (mods & SHIFT_MASK) != 8'h00;
	endfunction

	function automatic logic [6:0] key_to_ascii(input logic [7:0] kc, input logic [7:0] mods);
		logic sh;
		sh = shifted(mods);
		// 8'h41 is 'A', 8'h61 is 'a'
		if (kc >= KC_LETTER_LO && kc <= KC_LETTER_HI)
			return 7'((sh ? 8'h41 : 8'h61) + (kc - KC_LETTER_LO));
		if (kc >= KC_DIGIT_LO && kc <= KC_DIGIT_HI)
			return 7'(sh ? digit_hi[int'(kc - KC_DIGIT_LO)] : digit_lo[int'(kc - KC_DIGIT_LO)]);
		if (kc == KC_GRAVE)
			return sh ? 7'h7e : 7'h60;
		if (kc >= KC_PUNCT_LO && kc <= KC_PUNCT_HI && kc != KC_NON_US_HASH)
			return 7'(sh ? punct_hi[int'(kc - KC_PUNCT_LO)] : punct_lo[int'(kc - KC_PUNCT_LO)]);
		return 7'h00;
	endfunction

	function automatic logic key_present(input logic [7:0] kc, input logic [5:0][7:0] keys);
		for (int i = 0; i < KEY_SLOTS; i++)
			if (keys[i] == kc)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [9:0] age_inc(input logic [9:0] v);
		return (v >= AGE_MAX) ? AGE_MAX : v + 10'd1;
	endfunction

	function automatic logic [5:0][7:0] slots(input logic [7:0] k0, input logic [7:0] k1 = 8'h00,
			input logic [7:0] k2 = 8'h00, input logic [7:0] k3 = 8'h00,
			input logic [7:0] k4 = 8'h00, input logic [7:0] k5 = 8'h00);
		return {k5, k4, k3, k2, k1, k0};
	endfunction

	task automatic add_event(input event_kind_t k, input logic [6:0] c);
		report_events.push_back('{kind: k, chr: c, last: 1'b0});
	endtask

	task automatic commit_held(input logic [7:0] mods);
		logic [6:0] ch;
		ch = key_to_ascii(held_kc, mods);
		if (ch != 7'h00)
			add_event(EV_CHAR, ch);
		held_on = 1'b0;
	endtask

	task automatic reset_decoder_state();
		cfg_timeout = RST_PENDING_TIMEOUT;
		cfg_delay   = RST_REPEAT_DELAY;
		cfg_period  = RST_REPEAT_PERIOD;
		last_keys = '0;
		held_on = 1'b0; held_kc = 8'h00; held_mods = 8'h00; held_age = 10'd0;
		rpt_on = 1'b0; rpt_kc = 8'h00; rpt_held = 10'd0; rpt_since = 10'd0;
	endtask

	// Decode one accepted item into the key events it must produce
	task automatic decode_item(input logic c, input logic [7:0] mods, input logic [5:0][7:0] keys);
		logic       sh, present, stop_scan;
		logic [7:0] kc;
		logic [6:0] ch;
		if (c) begin
			held_age  = age_inc(held_age);
			rpt_held  = age_inc(rpt_held);
			rpt_since = age_inc(rpt_since);
			n_ticks++;
			return;
		end
		n_reports++;
		report_events.delete();
		sh = shifted(mods);

		// Settle the held key first
		if (held_on) begin
			present = key_present(held_kc, keys);
			if (present && sh)
				commit_held(mods);
			else if (!present)
				commit_held(held_mods);
			else if (held_age >= cfg_timeout)
				commit_held(held_mods);
		end

		// Walk newly pressed keys in slot order
		stop_scan = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			kc = keys[i];
			if (!stop_scan && kc != 8'h00 && !key_present(kc, last_keys)) begin
				case (kc)
					KC_ESCAPE: begin
						held_on = 1'b0;
						add_event(EV_ESCAPE, 7'h00);
						stop_scan = 1'b1;
					end
					KC_ENTER: begin
						if (held_on)
							commit_held(sh ? mods : held_mods);
						add_event(EV_ENTER, 7'h00);
					end
					KC_BACKSPACE: begin
						if (held_on)
							held_on = 1'b0;
						else
							add_event(EV_BACKSPACE, 7'h00);
					end
					KC_LEFT, KC_RIGHT: begin
						if (held_on)
							commit_held(held_mods);
						add_event(kc == KC_LEFT ? EV_LEFT : EV_RIGHT, 7'h00);
					end
					default: begin
						ch = key_to_ascii(kc, mods);
						if (ch != 7'h00) begin
							rpt_on = 1'b1; rpt_kc = kc; rpt_held = 10'd0; rpt_since = 10'd0;
							if (sh) begin
								add_event(EV_CHAR, ch);
							end else begin
								if (held_on)
									commit_held(held_mods);
								held_on = 1'b1; held_kc = kc; held_mods = mods; held_age = 10'd0;
							end
						end
					end
				endcase
			end
		end

		// Typematic repeat, skipped while the repeat key is still held back
		if (rpt_on && !(held_on && held_kc == rpt_kc)) begin
			if (!key_present(rpt_kc, keys)) begin
				rpt_on = 1'b0;
				rpt_kc = 8'h00;
			end else if (rpt_held >= cfg_delay && rpt_since >= cfg_period) begin
				ch = key_to_ascii(rpt_kc, mods);
				if (ch != 7'h00)
					add_event(EV_CHAR, ch);
				rpt_since = 10'd0;
			end
		end

		last_keys = keys;
		if (report_events.size() > 0)
			report_events[report_events.size() - 1].last = 1'b1;
		foreach (report_events[i])
			expected_events.push_back(report_events[i]);
	endtask

	// Send one item and hold it until the transfer
	task automatic send_item(input logic c, input logic [7:0] mods, input logic [5:0][7:0] keys);
		in_valid = 1'b1;
		cmd = c;
		modifier_bits = mods;
		{key_slot_5, key_slot_4, key_slot_3, key_slot_2, key_slot_1, key_slot_0} = keys;
		do @(posedge clk); while (!in_ready);
		decode_item(c, mods, keys);
		@(negedge clk);
		in_valid = 1'b0;
		if (!no_idle && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) @(negedge clk);
	endtask

	task automatic send_report(input logic [7:0] mods, input logic [5:0][7:0] keys);
		send_item(1'b0, mods, keys);
	endtask

	// Ticks carry random payload, which the block must ignore
	task automatic send_tick();
		send_item(1'b1, 8'($urandom), 48'({$urandom, $urandom}));
	endtask

	task automatic wait_idle(input int extra);
		while (expected_events.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [9:0] value);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = {22'($urandom), value};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		case (idx)
			REG_PENDING_TIMEOUT: cfg_timeout = value;
			REG_REPEAT_DELAY:    cfg_delay   = value;
			REG_REPEAT_PERIOD:   cfg_period  = value;
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic apb_read_check(input logic [1:0] idx, input logic [9:0] value);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b0;
		paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata[9:0] !== value) begin
			$error("prdata mismatch at register %0d: expected %0d, actual %0d",
				idx, value, prdata[9:0]);
			fail_count++;
		end
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
	endtask

	task automatic set_registers(input logic [9:0] t, input logic [9:0] d, input logic [9:0] p);
		wait_idle(DRAIN_CYCLES);
		apb_write(REG_PENDING_TIMEOUT, t);
		apb_write(REG_REPEAT_DELAY, d);
		apb_write(REG_REPEAT_PERIOD, p);
		n_settings++;
	endtask

	function automatic logic [7:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 8'($urandom_range(KC_LETTER_LO, KC_PUNCT_HI));
		if (r < 75) begin
			case ($urandom_range(0, 4))
				0: return KC_ENTER;
				1: return KC_ESCAPE;
				2: return KC_BACKSPACE;
				3: return KC_LEFT;
				default: return KC_RIGHT;
			endcase
		end
		if (r < 85)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(KC_LETTER_LO, KC_LETTER_HI));
	endfunction

	// Plain events, held-key handling, unmapped codes and duplicates at reset settings
	task automatic test_basic_events();
		send_report(8'h00, slots(8'h04));                          // held 'a'
		send_report(8'h02, slots(8'h04));                          // Shift commits 'A'
		send_report(8'h00, '0);
		send_report(8'h20, slots(KC_LETTER_HI));                   // right Shift, at once
		send_report(8'h00, '0);
		send_report(8'h00, slots(KC_DIGIT_HI));                    // held '0'
		send_report(8'h00, '0);                                    // release commits
		send_report(8'h00, slots(8'h05, KC_ENTER));                // Enter commits held
		send_report(8'h00, '0);
		send_report(8'h00, slots(8'h06, KC_BACKSPACE));            // Backspace drops held
		send_report(8'h00, '0);
		send_report(8'h00, slots(KC_BACKSPACE));                   // plain Backspace
		send_report(8'h00, slots(8'h07, KC_LEFT, KC_RIGHT));
		send_report(8'h00, '0);
		send_report(8'h00, slots(8'h08, KC_ESCAPE, 8'h09));        // Escape ends the scan
		send_report(8'h00, '0);
		send_report(8'h00, slots(KC_NON_US_HASH, 8'h01, 8'hff, 8'h39, 8'h80));
		send_report(8'h22, slots(8'h0a, 8'h0a));                   // duplicates
		send_report(8'hff, {6{8'hff}});
		send_report(8'h00, '0);
		send_report(8'h22, slots(8'h04, 8'h1e, KC_PUNCT_LO, KC_GRAVE, KC_PUNCT_HI, 8'h31));
		send_report(8'h00, slots(KC_GRAVE, 8'h34, KC_ENTER, KC_LEFT, 8'h2d, KC_RIGHT));
		send_report(8'h00, '0);
	endtask

	// Register writes and reads, an unused index, and zero timeouts
	task automatic test_register_access();
		wait_idle(DRAIN_CYCLES);
		apb_read_check(REG_PENDING_TIMEOUT, RST_PENDING_TIMEOUT);
		apb_read_check(REG_REPEAT_DELAY, RST_REPEAT_DELAY);
		apb_read_check(REG_REPEAT_PERIOD, RST_REPEAT_PERIOD);
		set_registers(10'd0, 10'd1023, 10'd0);
		apb_write(REG_UNUSED, 10'h2aa);
		apb_read_check(REG_PENDING_TIMEOUT, 10'd0);
		apb_read_check(REG_REPEAT_DELAY, 10'd1023);
		apb_read_check(REG_REPEAT_PERIOD, 10'd0);
		set_registers(10'd0, 10'd0, 10'd0);
		send_report(8'h00, slots(8'h0d));                          // held 'j'
		send_report(8'h00, slots(8'h0d));                          // timeout, then repeat
		send_report(8'h00, slots(8'h0d));
		send_report(8'h00, '0);
	endtask

	// Age counters meet the registers one tick short and exactly at the limit
	task automatic test_age_limits();
		set_registers(10'd40, 10'd50, 10'd20);
		send_report(8'h00, slots(8'h0c));                          // held 'i'
		repeat (39) send_tick();
		send_report(8'h00, slots(8'h0c));                          // one short, still held
		send_tick();
		send_report(8'h00, slots(8'h0c));                          // timeout commits
		repeat (10) send_tick();
		send_report(8'h10, slots(8'h0c));                          // first repeat
		repeat (20) send_tick();
		send_report(8'h02, slots(8'h0c));                          // shifted repeat
		send_report(8'h00, '0);
	endtask

	// Typing sessions with random content, plus some raw noise
	task automatic test_random_typing(input int n_items);
		logic [5:0][7:0] down;
		logic [7:0]      mods;
		int              sent, r, burst;
		down = '0;
		mods = 8'h00;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				burst = $urandom_range(1, 6);
				repeat (burst) send_tick();
				sent += burst;
			end else if (r < 82) begin
				case ($urandom_range(0, 4))
					0, 1: down[$urandom_range(0, 5)] = pick_key();
					2:    down[$urandom_range(0, 5)] = 8'h00;
					3: begin
						mods = 8'($urandom) & ~SHIFT_MASK;
						if ($urandom_range(0, 1))
							mods |= ($urandom_range(0, 2) == 0) ? 8'h02 :
								($urandom_range(0, 1) ? 8'h20 : 8'h22);
					end
					default: ;
				endcase
				send_report(mods, down);
				sent++;
			end else if (r < 92) begin
				send_report(8'($urandom), 48'({$urandom, $urandom}));
				sent++;
			end else begin
				down = '0;
				send_report(mods, down);
				sent++;
			end
			// Hold off now and then until the block has drained
			if (!no_idle && $urandom_range(0, 49) == 0)
				wait_idle(0);
		end
	endtask

	// Output-side stalls in short bursts
	always @(negedge clk) begin
		if (no_idle) begin
			out_ready = 1'b1;
		end else if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 4) == 0) begin
			out_ready = 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			out_ready = 1'b1;
		end
	end

	// Compare each event transfer with the oldest expectation
	always @(posedge clk) begin : check_events
		key_event_t want;
		if (arst_n && out_valid && out_ready) begin
			n_events++;
			if (expected_events.size() == 0) begin
				$error("event with nothing expected: event_kind %0d char_code %0h last_of_run %0b",
					event_kind, char_code, last_of_run);
				fail_count++;
			end else begin
				want = expected_events.pop_front();
				if (event_kind !== want.kind) begin
					$error("event_kind mismatch: expected %0d, actual %0d", want.kind, event_kind);
					fail_count++;
				end
				if (char_code !== want.chr) begin
					$error("char_code mismatch: expected %0h, actual %0h", want.chr, char_code);
					fail_count++;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run mismatch: expected %0b, actual %0b",
						want.last, last_of_run);
					fail_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events outstanding",
				cycle_count, expected_events.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = 1'b0;
		modifier_bits = 8'h00;
		{key_slot_5, key_slot_4, key_slot_3, key_slot_2, key_slot_1, key_slot_0} = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		reset_decoder_state();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_events();
		test_register_access();
		test_age_limits();
		set_registers(10'd2, 10'd8, 10'd3);
		test_random_typing(55);
		set_registers(10'd0, 10'd0, 10'd0);
		test_random_typing(45);
		set_registers(10'($urandom_range(0, 10)), 10'($urandom_range(0, 30)),
			10'($urandom_range(0, 15)));
		test_random_typing(55);
		// Final stretch at full rate on both sides
		no_idle = 1'b1;
		set_registers(10'd1023, 10'd0, 10'd1);
		test_random_typing(65);
		wait_idle(DRAIN_CYCLES);

		$display("Decoded %0d reports and %0d ticks under %0d register settings.",
			n_reports, n_ticks, n_settings);
		$display("Checked %0d key events, %0d failures.", n_events, fail_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
